// File: hdl/kvlt_pkg.sv
package kvlt_pkg;

	// Upper bound on the line buffers; capacities above it are clamped.
	localparam int LINE_CAPACITY = 256;
	localparam int CAP_LIMIT     = (LINE_CAPACITY < 256) ? LINE_CAPACITY : 256;

	localparam int CAP_W   = 9;
	localparam int COUNT_W = 8;

	// Configuration register indexes
	localparam logic [1:0] REG_KEY_CAP   = 2'd0;
	localparam logic [1:0] REG_VALUE_CAP = 2'd1;

	// Emit kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// Line error / status codes (shared encoding)
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_SKIP = 2'd1;
	localparam logic [1:0] ERR_FAIL = 2'd2;

	// Characters
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0] emit_kind;
		logic [7:0] emit_char;
		logic       line_end;
		logic [1:0] status;
		logic [7:0] key_length;
		logic [7:0] value_length;
	} result_t;

	// Clamped capacities
	typedef struct packed {
		logic [CAP_W-1:0] key_cap;
		logic [CAP_W-1:0] value_cap;
	} cfg_t;

	// Character as classified by the front end
	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] ch_upper;
		logic       last;
		logic       is_zero;
		logic       is_hash;
		logic       is_eq;
		logic       is_space;
		logic       is_letter;
		logic       is_key_char;
		logic       is_ctrl;
		logic       is_crlf;
	} class_t;

endpackage

// File: hdl/kvlt_front.sv
module kvlt_front
	import kvlt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	output logic   q_valid,
	output class_t q_head,
	input  logic   q_take
);

	class_t     cls;
	class_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;
	logic       upper_lc;
	logic       lower_lc;
	logic       digit;

	always_comb begin
		upper_lc        = (item.ch >= 8'h41) && (item.ch <= 8'h5A);
		lower_lc        = (item.ch >= 8'h61) && (item.ch <= 8'h7A);
		digit           = (item.ch >= 8'h30) && (item.ch <= 8'h39);
		cls.ch          = item.ch;
		cls.ch_upper    = lower_lc ? (item.ch - 8'd32) : item.ch;
		cls.last        = item.last;
		cls.is_zero     = (item.ch == 8'h00);
		cls.is_hash     = (item.ch == CH_HASH);
		cls.is_eq       = (item.ch == CH_EQ);
		cls.is_space    = (item.ch == CH_SPACE);
		cls.is_letter   = upper_lc || lower_lc;
		cls.is_key_char = upper_lc || lower_lc || digit || (item.ch == CH_UNDER);
		cls.is_ctrl     = (item.ch < 8'd32) || (item.ch == CH_DEL);
		cls.is_crlf     = (item.ch == CH_LF) || (item.ch == CH_CR);
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = mem_q[rd_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= ~wr_q;
			if (rd_en) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// File: hdl/kvlt_back.sv
module kvlt_back
	import kvlt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  class_t  q_head,
	output logic    q_take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_KEY    = 3'd1;
	localparam logic [2:0] PH_PRE_EQ = 3'd2;
	localparam logic [2:0] PH_POST_EQ = 3'd3;
	localparam logic [2:0] PH_VALUE  = 3'd4;

	logic [2:0]         phase_q;
	logic [COUNT_W-1:0] key_cnt_q;
	logic [COUNT_W-1:0] val_cnt_q;
	logic [1:0]         err_q;
	logic               halted_q;

	logic [2:0]         phase_n;
	logic [COUNT_W-1:0] key_cnt_n;
	logic [COUNT_W-1:0] val_cnt_n;
	logic [1:0]         err_n;
	logic               halted_n;
	logic               cap_bad;
	logic               key_full;
	logic               val_full;
	result_t            res;

	result_t    out_q [2];
	logic       owr_q;
	logic       ord_q;
	logic [1:0] ocnt_q;
	logic       out_rd;
	logic       out_room;

	assign empty    = (ocnt_q == 2'd0);
	assign result   = out_q[ord_q];
	assign out_rd   = pop && !empty;
	assign out_room = (ocnt_q != 2'd2) || out_rd;
	assign q_take   = q_valid && out_room;

	always_comb begin
		phase_n   = phase_q;
		key_cnt_n = key_cnt_q;
		val_cnt_n = val_cnt_q;
		err_n     = err_q;
		halted_n  = halted_q;
		res       = '0;
		cap_bad   = (cfg.key_cap == '0) || (cfg.value_cap == '0);
		key_full  = ({1'b0, key_cnt_q} + 9'd1) >= cfg.key_cap;
		val_full  = ({1'b0, val_cnt_q} + 9'd1) >= cfg.value_cap;

		if (err_q == ERR_NONE && !halted_q) begin
			if (q_head.is_zero) begin
				halted_n = 1'b1;
			end else if (cap_bad || key_full || val_full) begin
				err_n = ERR_FAIL;
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (q_head.is_hash) begin
							err_n = ERR_SKIP;
						end else if (q_head.is_letter) begin
							res.emit_kind = KIND_KEY;
							res.emit_char = q_head.ch_upper;
							key_cnt_n     = key_cnt_q + 8'd1;
							phase_n       = PH_KEY;
						end else if (!q_head.is_space) begin
							err_n = ERR_FAIL;
						end
					end
					PH_KEY: begin
						if (q_head.is_space) begin
							phase_n = PH_PRE_EQ;
						end else if (q_head.is_eq) begin
							phase_n = PH_POST_EQ;
						end else if (q_head.is_key_char) begin
							res.emit_kind = KIND_KEY;
							res.emit_char = q_head.ch_upper;
							key_cnt_n     = key_cnt_q + 8'd1;
						end else begin
							err_n = ERR_FAIL;
						end
					end
					PH_PRE_EQ: begin
						if (q_head.is_eq) begin
							phase_n = PH_POST_EQ;
						end else if (!q_head.is_space) begin
							err_n = ERR_FAIL;
						end
					end
					PH_POST_EQ: begin
						if (!q_head.is_space && !q_head.is_ctrl) begin
							res.emit_kind = KIND_VALUE;
							res.emit_char = q_head.ch;
							val_cnt_n     = val_cnt_q + 8'd1;
							phase_n       = PH_VALUE;
						end
					end
					default: begin
						if (!q_head.is_crlf) begin
							res.emit_kind = KIND_VALUE;
							res.emit_char = q_head.ch;
							val_cnt_n     = val_cnt_q + 8'd1;
						end
					end
				endcase
			end
		end

		if (q_head.last) begin
			res.line_end     = 1'b1;
			res.status       = cap_bad ? ERR_FAIL :
			                   (phase_n == PH_START) ? ERR_SKIP : err_n;
			res.key_length   = key_cnt_n;
			res.value_length = val_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			out_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			key_cnt_q <= '0;
			val_cnt_q <= '0;
			err_q     <= ERR_NONE;
			halted_q  <= 1'b0;
			owr_q     <= 1'b0;
			ord_q     <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			if (q_take) begin
				if (q_head.last) begin
					phase_q   <= PH_START;
					key_cnt_q <= '0;
					val_cnt_q <= '0;
					err_q     <= ERR_NONE;
					halted_q  <= 1'b0;
				end else begin
					phase_q   <= phase_n;
					key_cnt_q <= key_cnt_n;
					val_cnt_q <= val_cnt_n;
					err_q     <= err_n;
					halted_q  <= halted_n;
				end
				owr_q <= ~owr_q;
			end
			if (out_rd) ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + {1'b0, q_take} - {1'b0, out_rd};
		end
	end

	// result queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue overflow");

	// a stopped line emits nothing
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_take && (halted_q || err_q != ERR_NONE)) |-> (res.emit_kind == KIND_NONE))
		else $error("emit after stop");

	// closing a line returns the parser to its start state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(q_take && q_head.last) |=>
		(phase_q == PH_START && key_cnt_q == '0 && val_cnt_q == '0 && !halted_q))
		else $error("line state not cleared");

	// status and lengths only on the closing beat
	a_mid_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(q_take && !q_head.last) |->
		(res.status == ERR_NONE && res.key_length == '0 && res.value_length == '0))
		else $error("status outside line end");

endmodule

// File: hdl/key_value_line_tokenizer.sv
// Channel  | Handshake          | Payload   | Beat taken when
// ---------+--------------------+-----------+---------------------------
// input    | push / full        | item      | push && !full
// result   | empty / pop        | result    | pop && !empty
// config   | cfg_we             | cfg_index, cfg_data | cfg_we
//
// One character beat per clock sustained while the result side keeps popping;
// a result passes through the front queue, then the parser stage into the
// result queue, before it is on the result ports and can be popped.
// The parser's phase/count update sets the rate.
// Reset (arst_n low) empties both queues, clears the line state and sets
// both capacities to 256.
// A stalled result side fills the 2-deep result queue, then the 2-deep
// front queue, after which full rises; each side stalls on its own.
module key_value_line_tokenizer
	import kvlt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input beats
	input  logic         push,
	output logic         full,
	input  item_t        item,
	// result beats
	output logic         empty,
	input  logic         pop,
	output result_t      result,
	// configuration writes
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] key_cap_q;
	logic [CAP_W-1:0] value_cap_q;
	cfg_t             cfg;
	logic             q_valid;
	class_t           q_head;
	logic             q_take;

	// capacity registers; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cap_q   <= 9'd256;
			value_cap_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_CAP:   key_cap_q   <= cfg_data;
				REG_VALUE_CAP: value_cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to the line buffer limit
	always_comb begin
		cfg.key_cap   = (key_cap_q > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : key_cap_q;
		cfg.value_cap = (value_cap_q > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : value_cap_q;
	end

	// front: classify and queue characters
	kvlt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_take  (q_take)
	);

	// back: parser state machine and result queue
	kvlt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: dv/tb_key_value_line_tokenizer.sv
module tb_key_value_line_tokenizer;
	import kvlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int          N_SETTINGS  = 10;
	localparam int          PHASE_CHARS = 35;   // random characters per capacity setting
	localparam int          HOLD_CYCLES = 60;   // long receiver hold-off
	localparam logic [7:0]  CH_NUL      = 8'h00;

	// Parser phases, as the line tokenizer walks KEY = VALUE
	typedef enum logic [2:0] {
		PH_START,
		PH_KEY,
		PH_PRE_EQ,
		PH_POST_EQ,
		PH_VALUE
	} line_phase_e;

	// One row of the directed table; want is only used where known is set
	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         known;
		result_t    want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	item_t            item_in = '0;
	logic             empty;
	logic             pop = 1'b0;
	result_t          result_out;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_KEY_CAP;
	logic [CAP_W-1:0] cfg_data = '0;

	// Predictor copy of registers and line state
	logic [CAP_W-1:0] key_cap_reg;
	logic [CAP_W-1:0] value_cap_reg;
	line_phase_e      phase;
	logic [7:0]       key_cnt;
	logic [7:0]       val_cnt;
	logic [1:0]       line_err;
	logic             line_halted;

	result_t     token_queue[$];   // expected tokens, oldest first
	stim_row_t   directed_rows[0:23];
	int unsigned key_caps[N_SETTINGS];
	int unsigned value_caps[N_SETTINGS];

	int unsigned mismatches = 0;
	int unsigned chars_sent = 0;
	int unsigned tokens_checked = 0;
	int unsigned lines_ok = 0;
	int unsigned lines_skip = 0;
	int unsigned lines_fail = 0;
	int unsigned cycle_count = 0;
	bit          tx_burst = 1'b0;
	bit          hold_off_req = 1'b0;

	key_value_line_tokenizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item_in),
		.empty    (empty),
		.pop      (pop),
		.result   (result_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d tokens outstanding", $time, token_queue.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_control(input logic [7:0] c);
		return c < 8'd32 || c == CH_DEL;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic void clear_line();
		phase       = PH_START;
		key_cnt     = '0;
		val_cnt     = '0;
		line_err    = ERR_NONE;
		line_halted = 1'b0;
	endfunction

	// Token for one accepted character; advances the line state
	function automatic result_t tokenize_char(input logic [7:0] c, input logic eol);
		result_t r;
		int      kc;
		int      vc;
		r  = '0;
		// capacities beyond the buffer limit are clamped
		kc = (key_cap_reg > CAP_LIMIT) ? CAP_LIMIT : int'(key_cap_reg);
		vc = (value_cap_reg > CAP_LIMIT) ? CAP_LIMIT : int'(value_cap_reg);
		if (line_err == ERR_NONE && !line_halted) begin
			if (c == CH_NUL) begin
				line_halted = 1'b1;
			end else if (kc == 0 || vc == 0 || int'(key_cnt) + 1 >= kc
					|| int'(val_cnt) + 1 >= vc) begin
				line_err = ERR_FAIL;
			end else begin
				case (phase)
				PH_START: begin
					if (c == CH_HASH) begin
						line_err = ERR_SKIP;
					end else if (is_letter(c)) begin
						r.emit_kind = KIND_KEY;
						r.emit_char = to_upper(c);
						key_cnt++;
						phase = PH_KEY;
					end else if (c != CH_SPACE) begin
						line_err = ERR_FAIL;
					end
				end
				PH_KEY: begin
					if (c == CH_SPACE) begin
						phase = PH_PRE_EQ;
					end else if (c == CH_EQ) begin
						phase = PH_POST_EQ;
					end else if (is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER) begin
						r.emit_kind = KIND_KEY;
						r.emit_char = to_upper(c);
						key_cnt++;
					end else begin
						line_err = ERR_FAIL;
					end
				end
				PH_PRE_EQ: begin
					if (c == CH_EQ) begin
						phase = PH_POST_EQ;
					end else if (c != CH_SPACE) begin
						line_err = ERR_FAIL;
					end
				end
				PH_POST_EQ: begin
					if (c != CH_SPACE && !is_control(c)) begin
						r.emit_kind = KIND_VALUE;
						r.emit_char = c;
						val_cnt++;
						phase = PH_VALUE;
					end
				end
				default: begin
					// CR/LF inside the value are dropped, the value carries on
					if (c != CH_LF && c != CH_CR) begin
						r.emit_kind = KIND_VALUE;
						r.emit_char = c;
						val_cnt++;
					end
				end
				endcase
			end
		end
		r.line_end = eol;
		if (eol) begin
			if (kc == 0 || vc == 0) begin
				r.status = ERR_FAIL;
			end else if (phase == PH_START) begin
				// a line that never left the start phase is a skip, error or not
				r.status = ERR_SKIP;
			end else begin
				r.status = line_err;
			end
			r.key_length   = key_cnt;
			r.value_length = val_cnt;
			clear_line();
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Token checking
	// ---------------------------------------------------------------
	function automatic void report_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		mismatches++;
	endfunction

	function automatic void check_token(input result_t got);
		result_t want;
		if (token_queue.size() == 0) begin
			$display("%0t: token beat with nothing expected, got %p", $time, got);
			mismatches++;
			return;
		end
		want = token_queue.pop_front();
		tokens_checked++;
		if (got.emit_kind !== want.emit_kind)
			report_field("emit_kind", want.emit_kind, got.emit_kind);
		if (got.emit_char !== want.emit_char)
			report_field("emit_char", want.emit_char, got.emit_char);
		if (got.line_end !== want.line_end)
			report_field("line_end", want.line_end, got.line_end);
		if (got.status !== want.status)
			report_field("status", want.status, got.status);
		if (got.key_length !== want.key_length)
			report_field("key_length", want.key_length, got.key_length);
		if (got.value_length !== want.value_length)
			report_field("value_length", want.value_length, got.value_length);
		if (want.line_end) begin
			case (want.status)
			ERR_NONE: lines_ok++;
			ERR_SKIP: lines_skip++;
			default:  lines_fail++;
			endcase
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [7:0] random_letter();
		return ($urandom_range(0, 1) != 0) ? 8'($urandom_range("a", "z"))
			: 8'($urandom_range("A", "Z"));
	endfunction

	function automatic logic [7:0] random_key_char();
		case ($urandom_range(0, 3))
		0:       return 8'($urandom_range("0", "9"));
		1:       return CH_UNDER;
		default: return random_letter();
		endcase
	endfunction

	function automatic logic [7:0] random_value_char();
		case ($urandom_range(0, 9))
		0:       return CH_CR;
		1:       return CH_LF;
		2:       return CH_SPACE;
		3:       return 8'($urandom_range(0, 255));
		default: return 8'($urandom_range(8'h21, 8'hFF));
		endcase
	endfunction

	// Offer one character beat; returns at the edge that takes it.
	// push is dropped here only when a gap is drawn, so back-to-back beats hold it high.
	task automatic send_char(input logic [7:0] c, input logic eol, input bit known,
			input result_t want);
		int      gap;
		result_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		item_in <= '{ch: c, last: eol};
		@(posedge clk);
		while (full) @(posedge clk);
		predicted = tokenize_char(c, eol);
		token_queue.push_back(known ? want : predicted);
		chars_sent++;
	endtask

	task automatic send_line(input logic [7:0] chars[$]);
		tx_burst = ($urandom_range(0, 4) == 0);
		foreach (chars[i])
			send_char(chars[i], i == chars.size() - 1, 1'b0, '0);
	endtask

	// Mostly well-formed lines with random content; the rest is damaged or noise
	task automatic send_random_line(input bit long_value);
		logic [7:0] chars[$];
		int         pick;
		int         n;
		pick = long_value ? 0 : $urandom_range(0, 99);
		if (pick < 90) begin
			repeat ($urandom_range(0, 2)) chars.push_back(CH_SPACE);
			chars.push_back(random_letter());
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 4);
			repeat (n) chars.push_back(random_key_char());
			repeat ($urandom_range(0, 2)) chars.push_back(CH_SPACE);
			chars.push_back(CH_EQ);
			repeat ($urandom_range(0, 2)) chars.push_back(CH_SPACE);
			if ($urandom_range(0, 3) == 0)
				chars.push_back(($urandom_range(0, 4) == 0) ? CH_DEL
					: 8'($urandom_range(1, 31)));
			// the long value runs the count up to the 8-bit limit
			n = long_value ? $urandom_range(254, 258) : $urandom_range(0, 8);
			repeat (n) chars.push_back(random_value_char());
			if ($urandom_range(0, 2) == 0) begin
				chars.push_back(CH_CR);
				chars.push_back(CH_LF);
			end
			if (long_value) begin
				// keep the long line clean
			end else if (pick >= 80) begin
				chars[$urandom_range(0, chars.size() - 1)] = CH_NUL;
			end else if (pick >= 65) begin
				chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(1, 255));
			end
		end else if (pick < 95) begin
			chars.push_back(CH_HASH);
			repeat ($urandom_range(0, 6)) chars.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3)) chars.push_back(CH_SPACE);
		end
		send_line(chars);
	endtask

	// Let every outstanding token come back, then leave a quiet tail
	task automatic drain(input int tail);
		push <= 1'b0;
		while (token_queue.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_caps(input int unsigned kcap, input int unsigned vcap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KEY_CAP;
		cfg_data  <= CAP_W'(kcap);
		@(posedge clk);
		key_cap_reg = CAP_W'(kcap);
		cfg_index <= REG_VALUE_CAP;
		cfg_data  <= CAP_W'(vcap);
		@(posedge clk);
		value_cap_reg = CAP_W'(vcap);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Result side: random pops, stretches of back-to-back pops, and one
	// long hold-off so the block fills and raises full
	// ---------------------------------------------------------------
	initial begin
		int gap;
		bit rx_burst;
		bit hold_done;
		rx_burst  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = rx_burst ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			check_token(result_out);
			if ($urandom_range(0, 23) == 0)
				rx_burst = !rx_burst;
			if (hold_off_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned phase_start;
		key_cap_reg   = 9'd256;
		value_cap_reg = 9'd256;
		clear_line();

		// Directed lines at the reset capacities of 256
		directed_rows = '{
			// single lower-case letter: key of one, upper-cased
			'{8'h61, 1'b1, 1'b1, {KIND_KEY, 8'h41, 1'b1, ERR_NONE, 8'd1, 8'd0}},
			// comment line
			'{CH_HASH, 1'b1, 1'b1, {KIND_NONE, 8'h00, 1'b1, ERR_SKIP, 8'd0, 8'd0}},
			// high byte at start is an error, but a start-phase end reads skip
			'{8'hFF, 1'b1, 1'b1, {KIND_NONE, 8'h00, 1'b1, ERR_SKIP, 8'd0, 8'd0}},
			// x_9 =<DEL> v<CR><LF><FF>: key chars, space before '=', control
			// dropped after '=', CR/LF dropped inside the value, high byte kept
			'{"x", 1'b0, 1'b0, '0},
			'{CH_UNDER, 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0},
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{CH_EQ, 1'b0, 1'b0, '0},
			'{CH_DEL, 1'b0, 1'b0, '0},
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{"v", 1'b0, 1'b0, '0},
			'{CH_CR, 1'b0, 1'b0, '0},
			'{CH_LF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, '0},
			// zero byte after '=' halts the line
			'{"k", 1'b0, 1'b0, '0},
			'{CH_EQ, 1'b0, 1'b0, '0},
			'{CH_NUL, 1'b0, 1'b0, '0},
			'{"q", 1'b1, 1'b0, '0},
			// bad key character
			'{"A", 1'b0, 1'b0, '0},
			'{"!", 1'b1, 1'b1, {KIND_NONE, 8'h00, 1'b1, ERR_FAIL, 8'd1, 8'd0}},
			// lone zero byte
			'{CH_NUL, 1'b1, 1'b1, {KIND_NONE, 8'h00, 1'b1, ERR_SKIP, 8'd0, 8'd0}},
			// leading space, then a key ending on '='
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{"Z", 1'b0, 1'b0, '0},
			'{CH_EQ, 1'b1, 1'b0, '0}
		};

		// Capacity settings: defaults, tiny, one, zero, above the clamp, random
		key_caps   = '{256, 3, 1, 256, 0, 256, 511, 2, 0, 0};
		value_caps = '{256, 5, 256, 1, 256, 0, 300, 2, 0, 0};
		key_caps[8]   = $urandom_range(1, 256);
		value_caps[8] = $urandom_range(1, 256);
		key_caps[9]   = $urandom_range(4, 16);
		value_caps[9] = $urandom_range(4, 16);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].last,
				directed_rows[i].known, directed_rows[i].want);

		for (int p = 0; p < N_SETTINGS; p++) begin
			// registers only change with the pipe empty
			drain(4);
			write_caps(key_caps[p], value_caps[p]);
			if (p == 1)
				hold_off_req = 1'b1;
			phase_start = chars_sent;
			if (p == 0)
				send_random_line(1'b1);
			while (chars_sent - phase_start < PHASE_CHARS)
				send_random_line(1'b0);
		end

		drain(8);
		$display("Checked %0d tokens from %0d characters over %0d capacity settings",
			tokens_checked, chars_sent, N_SETTINGS);
		$display("Lines closed: %0d ok, %0d skipped, %0d in error; %0d mismatches",
			lines_ok, lines_skip, lines_fail, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/kvlt_pkg.sv
hdl/kvlt_front.sv
hdl/kvlt_back.sv
hdl/key_value_line_tokenizer.sv
dv/tb_key_value_line_tokenizer.sv
